[design/srmc_pkg.sv]
// Shared types and codes for the servo ramp mode controller.
`default_nettype none

package srmc_pkg;

  // Stored mode codes; codes ten to fifteen may be stored and act as no update.
  typedef enum logic [3:0] {
    MODE_DEACTIVE   = 4'd0,
    MODE_NORMAL     = 4'd1,
    MODE_RAMPDOWN   = 4'd2,
    MODE_RAMPUP     = 4'd3,
    MODE_DEADLOW    = 4'd4,
    MODE_ACTIVEHIGH = 4'd5,
    MODE_STANDBY    = 4'd6,
    MODE_SENSOR     = 4'd7,
    MODE_IMMEDIATE  = 4'd8,
    MODE_NOUPDATE   = 4'd9
  } mode_t;

  // Request kinds; the fourth code is ignored.
  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_MODE_WRITE = 2'd1,
    KIND_INIT       = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOW_SETTING  = 2'd0;
  localparam logic [1:0] REG_HIGH_SETTING = 2'd1;
  localparam logic [1:0] REG_STEP_SIZE    = 2'd2;

  localparam logic [7:0] LOW_SETTING_RESET  = 8'd90;
  localparam logic [7:0] HIGH_SETTING_RESET = 8'd0;
  localparam logic [7:0] STEP_SIZE_RESET    = 8'd1;

  typedef struct packed {
    kind_t       kind;
    mode_t       new_mode;
    logic        local_sensor;
    logic        any_sensor_updated;
    logic        actuation_on;
  } item_t;

  typedef struct packed {
    mode_t       stored_mode;
    logic [7:0]  current_angle;
    logic [7:0]  written_angle;
    logic [7:0]  step_size;
  } chan_state_t;

endpackage

`default_nettype wire

[design/srmc_in_reg.sv]
// Input register stage: holds one accepted request until the step logic takes it.
`default_nettype none

module srmc_in_reg
  import srmc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // new_mode[3:0], local_sensor[4],
                                     // any_sensor_updated[5], actuation_on[6], zero[7]
  input  wire logic [1:0] s_tuser,   // kind[1:0]
  input  wire logic       advance,
  output logic            in_valid,
  output item_t           item
);

  // A held request leaves when the next stage advances.
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.kind               <= kind_t'(s_tuser);
      item.new_mode           <= mode_t'(s_tdata[3:0]);
      item.local_sensor       <= s_tdata[4];
      item.any_sensor_updated <= s_tdata[5];
      item.actuation_on       <= s_tdata[6];
    end
  end

endmodule

`default_nettype wire

[design/srmc_step.sv]
// Combinational step logic: next channel state and write strobe for one request.
`default_nettype none

module srmc_step
  import srmc_pkg::*;
(
  input  wire item_t       item,
  input  wire chan_state_t st,
  input  wire logic [7:0]  low_setting,
  input  wire logic [7:0]  high_setting,
  output chan_state_t      st_next,
  output logic             strobe
);

  logic [8:0] up_sum;
  logic [8:0] down_diff;
  logic       up_clamp;
  logic       down_clamp;
  logic [7:0] up_angle;
  logic [7:0] down_angle;
  mode_t      act_mode;

  // Stepping toward the low setting (add) and toward the high setting (subtract).
  always_comb begin
    up_sum     = {1'b0, st.current_angle} + {1'b0, st.step_size};
    up_clamp   = (up_sum >= {1'b0, low_setting});
    up_angle   = up_clamp ? low_setting : up_sum[7:0];
    down_diff  = {1'b0, st.current_angle} - {1'b0, st.step_size};
    down_clamp = down_diff[8] || (down_diff[7:0] <= high_setting);
    down_angle = down_clamp ? high_setting : down_diff[7:0];
  end

  // The local sensor overrides the stored mode for this tick only.
  assign act_mode = item.local_sensor ? MODE_SENSOR : st.stored_mode;

  always_comb begin
    st_next = st;
    strobe  = 1'b0;
    unique case (item.kind)
      KIND_TICK: begin
        // The update flag turns a running ramp into active-high unless the ramp reverses this tick.
        if (item.any_sensor_updated &&
            (st.stored_mode == MODE_RAMPDOWN || st.stored_mode == MODE_RAMPUP)) begin
          st_next.stored_mode = MODE_ACTIVEHIGH;
        end
        unique case (act_mode)
          MODE_NORMAL: begin
            st_next.current_angle = item.actuation_on ? high_setting : low_setting;
            st_next.stored_mode   = MODE_NOUPDATE;
          end
          MODE_RAMPDOWN: begin
            st_next.current_angle = up_angle;
            if (up_clamp) st_next.stored_mode = MODE_RAMPUP;
          end
          MODE_RAMPUP: begin
            st_next.current_angle = down_angle;
            if (down_clamp) st_next.stored_mode = MODE_RAMPDOWN;
          end
          MODE_DEADLOW: begin
            st_next.current_angle = up_angle;
            if (up_clamp) st_next.stored_mode = MODE_NOUPDATE;
          end
          MODE_ACTIVEHIGH: begin
            st_next.current_angle = down_angle;
            if (down_clamp) st_next.stored_mode = MODE_STANDBY;
          end
          MODE_SENSOR: begin
            st_next.current_angle = up_angle;
          end
          MODE_IMMEDIATE: begin
            st_next.current_angle = high_setting;
          end
          default: begin
          end
        endcase
        // Send the angle when it moved and the channel is not deactivated.
        if (st_next.stored_mode != MODE_DEACTIVE &&
            st_next.current_angle != st.written_angle) begin
          st_next.written_angle = st_next.current_angle;
          strobe                = 1'b1;
        end
      end
      KIND_MODE_WRITE: begin
        st_next.stored_mode = item.new_mode;
      end
      KIND_INIT: begin
        // Initialise forces a send of the rest angle and resets the step.
        if (st.stored_mode != MODE_DEACTIVE) begin
          st_next.current_angle = low_setting;
          st_next.written_angle = low_setting;
          st_next.step_size     = 8'd1;
          strobe                = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[design/servo_ramp_mode_controller.sv]
// Top level of the servo ramp mode controller: state, settings and result register.
// A request accepted into the input register passes through the step logic into the
// result register when that register is empty or being drained.
// Throughput: one request per cycle unless the result is stalled; the step logic between
// the input register and the result register is a single add, subtract and compare.
// Reset (synchronous, active high): settings 90/0/1, mode no update, angles 90,
// both register stages empty.
`default_nettype none

module servo_ramp_mode_controller
  import srmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // new_mode[3:0], local_sensor[4],
                                      // any_sensor_updated[5], actuation_on[6], zero[7]
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // angle[7:0], write_strobe[8], mode_now[12:9],
                                      // zero[15:13]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic        advance;
  logic        in_valid;
  logic        proc;
  item_t       item;
  chan_state_t st;
  chan_state_t st_next;
  logic        strobe;
  logic [7:0]  low_setting;
  logic [7:0]  high_setting;
  logic [7:0]  out_angle;
  logic        out_strobe;
  mode_t       out_mode;

  // The result register is free when empty or being drained.
  assign advance = !m_tvalid || m_tready;
  assign proc    = in_valid && advance;

  srmc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .in_valid (in_valid),
    .item     (item)
  );

  srmc_step u_step (
    .item         (item),
    .st           (st),
    .low_setting  (low_setting),
    .high_setting (high_setting),
    .st_next      (st_next),
    .strobe       (strobe)
  );

  // Settings and channel state; initialise may also rewrite the step size.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_setting      <= LOW_SETTING_RESET;
      high_setting     <= HIGH_SETTING_RESET;
      st.step_size     <= STEP_SIZE_RESET;
      st.stored_mode   <= MODE_NOUPDATE;
      st.current_angle <= LOW_SETTING_RESET;
      st.written_angle <= LOW_SETTING_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LOW_SETTING:  low_setting  <= cfg_data;
          REG_HIGH_SETTING: high_setting <= cfg_data;
          REG_STEP_SIZE:    st.step_size <= cfg_data;
          default: begin
          end
        endcase
      end
      if (proc) begin
        st <= st_next;
      end
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (proc) begin
      out_angle  <= st_next.current_angle;
      out_strobe <= strobe;
      out_mode   <= st_next.stored_mode;
    end
  end

  assign m_tdata = {3'b000, out_mode, out_strobe, out_angle};

  // A stalled result freezes the channel's current angle and stored mode.
  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(st.current_angle) && $stable(st.stored_mode))
    else $error("channel state changed while the result was stalled");

  // A strobed result carries the angle last sent to the servo.
  a_strobe_matches_sent: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_strobe) |-> (out_angle == st.written_angle))
    else $error("strobed angle differs from the sent angle");

  // A deactivated channel never strobes.
  a_no_strobe_deactive: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_strobe) |-> (out_mode != MODE_DEACTIVE))
    else $error("write strobe with deactivated mode");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

[sim/srmc_checker.sv]
// Checker for the servo ramp mode controller: predicts each result and compares it.
module srmc_checker
  import srmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // new_mode[3:0], local_sensor[4],
                                 // any_sensor_updated[5], actuation_on[6], zero[7]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // angle[7:0], write_strobe[8], mode_now[12:9],
                                 // zero[15:13]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [7:0] angle;
    logic       strobe;
    logic [3:0] mode;
  } servo_resp_t;

  // Channel state and settings as the block should hold them.
  logic [7:0] low_set;
  logic [7:0] high_set;
  logic [7:0] step_amt;
  logic [7:0] cur_angle;
  logic [7:0] sent_angle;
  logic [3:0] mode_reg;

  servo_resp_t resp_q[$];

  initial fails = 0;

  // Add one step and stop at the low setting; returns 1 when the stop was hit.
  function automatic logic step_to_low();
    logic [8:0] sum;
    sum = {1'b0, cur_angle} + {1'b0, step_amt};
    if (sum >= {1'b0, low_set}) begin
      cur_angle = low_set;
      return 1'b1;
    end
    cur_angle = sum[7:0];
    return 1'b0;
  endfunction

  // Subtract one step and stop at the high setting; going below zero also stops.
  function automatic logic step_to_high();
    if (step_amt > cur_angle || cur_angle - step_amt <= high_set) begin
      cur_angle = high_set;
      return 1'b1;
    end
    cur_angle = cur_angle - step_amt;
    return 1'b0;
  endfunction

  // Apply one request to the channel state and return the result it should give.
  function automatic servo_resp_t next_response(input logic [1:0] kind,
                                                input logic [7:0] data);
    servo_resp_t r;
    logic [3:0]  run_mode;
    logic        strobe;
    logic        sensor;
    logic        updated;
    logic        act_on;
    sensor  = data[4];
    updated = data[5];
    act_on  = data[6];
    strobe  = 1'b0;
    case (kind)
      KIND_TICK: begin
        // The update flag re-arms a ramp, but this tick still steps the old one.
        run_mode = mode_reg;
        if (updated && (mode_reg == MODE_RAMPDOWN || mode_reg == MODE_RAMPUP)) begin
          mode_reg = MODE_ACTIVEHIGH;
        end
        if (sensor) begin
          run_mode = MODE_SENSOR;
        end
        case (run_mode)
          MODE_NORMAL: begin
            cur_angle = act_on ? high_set : low_set;
            mode_reg  = MODE_NOUPDATE;
          end
          MODE_RAMPDOWN:   if (step_to_low())  mode_reg = MODE_RAMPUP;
          MODE_RAMPUP:     if (step_to_high()) mode_reg = MODE_RAMPDOWN;
          MODE_DEADLOW:    if (step_to_low())  mode_reg = MODE_NOUPDATE;
          MODE_ACTIVEHIGH: if (step_to_high()) mode_reg = MODE_STANDBY;
          MODE_SENSOR:     void'(step_to_low());
          MODE_IMMEDIATE:  cur_angle = high_set;
          default: ;
        endcase
        // Send the angle only when it moved and the channel is not deactive.
        if (mode_reg != MODE_DEACTIVE && sent_angle != cur_angle) begin
          sent_angle = cur_angle;
          strobe     = 1'b1;
        end
      end
      KIND_MODE_WRITE: mode_reg = data[3:0];
      KIND_INIT: begin
        // Initialise also drops the step size back to one.
        if (mode_reg != MODE_DEACTIVE) begin
          cur_angle  = low_set;
          sent_angle = low_set;
          step_amt   = 8'd1;
          strobe     = 1'b1;
        end
      end
      default: ;
    endcase
    r.angle  = cur_angle;
    r.strobe = strobe;
    r.mode   = mode_reg;
    return r;
  endfunction

  // Watch the channel; results are compared before new requests are queued.
  always @(posedge clk) begin
    servo_resp_t want;
    servo_resp_t got;
    if (rst) begin
      low_set    = LOW_SETTING_RESET;
      high_set   = HIGH_SETTING_RESET;
      step_amt   = STEP_SIZE_RESET;
      cur_angle  = LOW_SETTING_RESET;
      sent_angle = LOW_SETTING_RESET;
      mode_reg   = MODE_NOUPDATE;
      resp_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.angle  = m_tdata[7:0];
        got.strobe = m_tdata[8];
        got.mode   = m_tdata[12:9];
        if (resp_q.size() == 0) begin
          fails++;
          $display("%0t: result with none expected: angle %0d strobe %0d mode %0d",
                   $time, got.angle, got.strobe, got.mode);
        end else begin
          want = resp_q.pop_front();
          if (got.angle !== want.angle)
            $display("%0t: angle expected %0d, got %0d", $time, want.angle, got.angle);
          if (got.strobe !== want.strobe)
            $display("%0t: write strobe expected %0d, got %0d",
                     $time, want.strobe, got.strobe);
          if (got.mode !== want.mode)
            $display("%0t: mode expected %0d, got %0d", $time, want.mode, got.mode);
          if (got !== want) fails++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW_SETTING:  low_set  = cfg_data;
          REG_HIGH_SETTING: high_set = cfg_data;
          REG_STEP_SIZE:    step_amt = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        resp_q.push_back(next_response(s_tuser, s_tdata));
      end
    end
    pending = resp_q.size();
  end

endmodule

[sim/tb.sv]
// Testbench top for the servo ramp mode controller: stimulus, stalls and verdict.
module tb;
  import srmc_pkg::*;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam logic [1:0] REG_SPARE    = 2'd3;
  localparam logic [3:0] MODE_UNUSED  = 4'hF;
  localparam int         QUIET_LIMIT  = 2000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          fails;
  int          pending;
  int          quiet;
  logic        no_gaps;

  servo_ramp_mode_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  srmc_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle cycles before a request or a result; zero during burst stretches.
  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 14);
  endfunction

  // Present one request and hold it until accepted; returns at a falling edge.
  task automatic send_req(input logic [1:0] kind, input logic [3:0] mode,
                          input logic sensor, input logic updated, input logic act_on);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, act_on, updated, sensor, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Angle settings: mostly in range, with the ends and out-of-range values mixed in.
  function automatic logic [7:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd180;
      2: return 8'($urandom_range(181, 255));
      default: return 8'($urandom_range(0, 180));
    endcase
  endfunction

  function automatic logic [7:0] pick_step();
    case ($urandom_range(0, 9))
      0: return 8'd1;
      1: return 8'd180;
      2: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(1, 24));
    endcase
  endfunction

  // Random request: mostly ticks, with mode writes between them and some noise.
  task automatic rand_req();
    int         pick;
    logic [3:0] mode;
    pick = $urandom_range(0, 99);
    mode = 4'($urandom_range(0, 15));
    if (pick < 64) begin
      send_req(KIND_TICK, mode, $urandom_range(0, 6) == 0, $urandom_range(0, 4) == 0,
               1'($urandom_range(0, 1)));
    end else if (pick < 90) begin
      // Ramp modes are favored so that ramps run long enough to reverse.
      if ($urandom_range(0, 9) < 5) begin
        case ($urandom_range(0, 3))
          0: mode = MODE_RAMPDOWN;
          1: mode = MODE_RAMPUP;
          2: mode = MODE_DEADLOW;
          default: mode = MODE_ACTIVEHIGH;
        endcase
      end
      send_req(KIND_MODE_WRITE, mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    end else if (pick < 95) begin
      send_req(KIND_INIT, mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    end else begin
      send_req(KIND_IGNORED, mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver: a random stall before each result, none during burst stretches.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog on cycles in which no request, result or register write moves.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("[servo_ramp_mode_controller] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_gaps   = 1'b0;
    quiet     = 0;
    rst       = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests with the reset settings: each kind, every mode but standby and no update.
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b0, 1'b0, 1'b0);
    send_req(KIND_IGNORED, MODE_UNUSED, 1'b1, 1'b1, 1'b1);
    send_req(KIND_INIT, MODE_NOUPDATE, 1'b0, 1'b0, 1'b0);
    send_req(KIND_MODE_WRITE, MODE_NORMAL, 1'b0, 1'b0, 1'b0);
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b0, 1'b0, 1'b1);
    send_req(KIND_MODE_WRITE, MODE_NORMAL, 1'b0, 1'b0, 1'b0);
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b0, 1'b0, 1'b0);
    send_req(KIND_MODE_WRITE, MODE_IMMEDIATE, 1'b0, 1'b0, 1'b0);
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b0, 1'b0, 1'b0);
    // Update flag during a ramp: old ramp steps, then active high takes over.
    send_req(KIND_MODE_WRITE, MODE_RAMPDOWN, 1'b0, 1'b0, 1'b0);
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b0, 1'b1, 1'b0);
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b0, 1'b0, 1'b0);
    // Ramp that ends on the same tick as the update flag: reversal wins.
    send_req(KIND_MODE_WRITE, MODE_RAMPUP, 1'b0, 1'b0, 1'b0);
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b0, 1'b1, 1'b0);
    // Local sensor overrides the stored mode for one tick.
    send_req(KIND_MODE_WRITE, MODE_DEADLOW, 1'b0, 1'b0, 1'b0);
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b1, 1'b0, 1'b0);
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b0, 1'b0, 1'b0);
    send_req(KIND_MODE_WRITE, MODE_SENSOR, 1'b0, 1'b0, 1'b0);
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b0, 1'b0, 1'b0);
    // Deactive blocks both the strobe and initialise.
    send_req(KIND_MODE_WRITE, MODE_DEACTIVE, 1'b0, 1'b0, 1'b0);
    send_req(KIND_TICK, MODE_DEACTIVE, 1'b1, 1'b0, 1'b0);
    send_req(KIND_INIT, MODE_DEACTIVE, 1'b0, 1'b0, 1'b0);
    // Codes above no update are stored and act like it.
    send_req(KIND_MODE_WRITE, MODE_UNUSED, 1'b0, 1'b0, 1'b0);
    send_req(KIND_TICK, MODE_UNUSED, 1'b0, 1'b1, 1'b1);

    // Random phases, each with its own settings; the first ones take the extremes.
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: begin
          cfg_write(REG_LOW_SETTING, 8'd180);
          cfg_write(REG_HIGH_SETTING, 8'd0);
          cfg_write(REG_STEP_SIZE, 8'd1);
        end
        1: begin
          cfg_write(REG_LOW_SETTING, 8'd0);
          cfg_write(REG_HIGH_SETTING, 8'd255);
          cfg_write(REG_STEP_SIZE, 8'd255);
        end
        2: begin
          cfg_write(REG_LOW_SETTING, 8'd255);
          cfg_write(REG_HIGH_SETTING, 8'd180);
          cfg_write(REG_STEP_SIZE, 8'd0);
          cfg_write(REG_SPARE, 8'd255);
        end
        default: begin
          cfg_write(REG_LOW_SETTING, pick_angle());
          cfg_write(REG_HIGH_SETTING, pick_angle());
          cfg_write(REG_STEP_SIZE, pick_step());
          if ($urandom_range(0, 2) == 0) cfg_write(REG_SPARE, 8'($urandom_range(0, 255)));
        end
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (50) rand_req();
    end

    drain();
    if (fails == 0 && pending == 0) begin
      $display("[servo_ramp_mode_controller] OK");
    end else begin
      $display("[servo_ramp_mode_controller] ERROR");
    end
    $finish;
  end

endmodule

[servo_ramp_mode_controller.f]
design/srmc_pkg.sv
design/srmc_in_reg.sv
design/srmc_step.sv
design/servo_ramp_mode_controller.sv
sim/srmc_checker.sv
sim/tb.sv
